>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

>>> design/smtpb_pkg.sv
// Shared constants, types and helpers of the sparse morph-target blender.
package smtpb_pkg;

  localparam int unsigned NUM_TARGETS        = 4;
  localparam int unsigned ENTRIES_PER_TARGET = 1024;
  localparam int unsigned MAX_VERTICES       = 65536;

  localparam int unsigned STORE_DEPTH = NUM_TARGETS * ENTRIES_PER_TARGET;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned TGT_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int unsigned LEN_W       = $clog2(ENTRIES_PER_TARGET + 1);
  localparam int unsigned VCNT_W      = $clog2(MAX_VERTICES);

  localparam int unsigned POS_W    = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VERT_W   = 16;
  localparam int unsigned TDATA_W  = 112;
  localparam int unsigned IN_TUSER_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_BLEND   = 2'd3
  } op_e;

  // One difference-list entry as held in the entry store.
  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
    logic [VERT_W-1:0]       vertex;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic load;        // start a vertex: take the base position
    logic lane_valid;  // a target's entry is on the read port
    logic lane_hit;    // that entry contributes
  } mac_ctrl_t;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [TGT_W-1:0] t,
                                                   input logic [LEN_W-1:0] c);
    return ADDR_W'(ADDR_W'(t) * ADDR_W'(ENTRIES_PER_TARGET)) + ADDR_W'(c);
  endfunction

endpackage

>>> design/smtpb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module smtpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/smtpb_mac.sv
// Difference, multiply and accumulate pipeline with final round and saturate.
module smtpb_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  smtpb_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [smtpb_pkg::POS_W-1:0]      base_x_i,
  input  logic signed [smtpb_pkg::POS_W-1:0]      base_y_i,
  input  logic signed [smtpb_pkg::POS_W-1:0]      base_z_i,
  input  logic signed [smtpb_pkg::WEIGHT_W-1:0]   weight_i,
  input  smtpb_pkg::entry_t                       entry_i,
  output logic signed [smtpb_pkg::POS_W-1:0]      res_x_o,
  output logic signed [smtpb_pkg::POS_W-1:0]      res_y_o,
  output logic signed [smtpb_pkg::POS_W-1:0]      res_z_o,
  output logic                                    clip_o,
  output logic                                    busy_o
);

  localparam int unsigned POS_W  = smtpb_pkg::POS_W;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned PROD_W = DIFF_W + smtpb_pkg::WEIGHT_W;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned FRAC_SHIFT = 12;

  logic signed [POS_W-1:0]  bx_q, by_q, bz_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [smtpb_pkg::WEIGHT_W-1:0] w_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [ACC_W-1:0]  ax_q, ay_q, az_q;
  logic a_v_q, a_hit_q, b_v_q, b_hit_q;
  logic cx, cy, cz;

  function automatic logic signed [ACC_W-1:0] scale_base(input logic signed [POS_W-1:0] b);
    logic signed [ACC_W-1:0] e;
    e = ACC_W'(b);
    return e <<< FRAC_SHIFT;
  endfunction

  // Round to nearest (ties up) by adding half an LSB and flooring, then saturate.
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [ACC_W-1:0] a,
                                                        output logic clip);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] q;
    logic [ACC_W-POS_W:0]    top;
    v    = a + ACC_W'(2048);
    q    = v >>> FRAC_SHIFT;
    top  = q[ACC_W-1:POS_W-1];
    clip = !((&top) || !(|top));
    if (!clip) begin
      return q[POS_W-1:0];
    end else if (q[ACC_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= ctrl_i.lane_valid;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      bx_q <= base_x_i;
      by_q <= base_y_i;
      bz_q <= base_z_i;
    end
    // target minus base, exact in one extra bit
    if (ctrl_i.lane_valid) begin
      dx_q    <= DIFF_W'(entry_i.x) - DIFF_W'(bx_q);
      dy_q    <= DIFF_W'(entry_i.y) - DIFF_W'(by_q);
      dz_q    <= DIFF_W'(entry_i.z) - DIFF_W'(bz_q);
      w_q     <= weight_i;
      a_hit_q <= ctrl_i.lane_hit;
    end
    if (a_v_q) begin
      px_q    <= PROD_W'(w_q) * PROD_W'(dx_q);
      py_q    <= PROD_W'(w_q) * PROD_W'(dy_q);
      pz_q    <= PROD_W'(w_q) * PROD_W'(dz_q);
      b_hit_q <= a_hit_q;
    end
    if (ctrl_i.load) begin
      ax_q <= scale_base(base_x_i);
      ay_q <= scale_base(base_y_i);
      az_q <= scale_base(base_z_i);
    end else if (b_v_q && b_hit_q) begin
      ax_q <= ax_q + ACC_W'(px_q);
      ay_q <= ay_q + ACC_W'(py_q);
      az_q <= az_q + ACC_W'(pz_q);
    end
  end

  always_comb begin
    res_x_o = round_sat(ax_q, cx);
    res_y_o = round_sat(ay_q, cy);
    res_z_o = round_sat(az_q, cz);
    clip_o  = cx | cy | cz;
  end

  assign busy_o = a_v_q | b_v_q;

endmodule

>>> design/sparse_morph_target_position_blend.sv
// Top level: sparse morph-target position blender with entry store and sequencer.
// Usage:
//  - Input stream (s_axis): one transaction per command. tuser carries the
//    operation (clear lists, append entry, restart pass, blend vertex) and the
//    target id; tdata carries the entry vertex index and an x/y/z position.
//  - Output stream (m_axis): one transaction per blend command, carrying the
//    vertex number and the blended Q16.16 position in tdata and the
//    saturation flag in tuser.
//  - Weights are written through the cfg port while the block is idle.
//  - Clear, restart and append are handled in the idle state; the next
//    transaction is taken in the following cycle.
//  - A blend walks the targets one per cycle through the single read port of
//    the entry store, then drains a three-stage difference/multiply/accumulate
//    pipe. The input stalls until the result is loaded into the output register,
//    and is ready again in the same cycle that the result becomes valid.
//  - The output register decouples the sides: a new command is taken while a
//    result waits; a finished blend holds in the drain state while the
//    receiver stalls with the output register full, and the input stalls.
//  - Reset clears weights, list lengths, cursors and the vertex counter; the
//    entry store itself is not cleared and only entries that were written are used.
module sparse_morph_target_position_blend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: entry_vertex[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80]
  input  logic [smtpb_pkg::TDATA_W-1:0]       s_axis_tdata,
  // tuser: operation[1:0], target_id[3:2]
  input  logic [smtpb_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: vertex_number[15:0], out_x[47:16], out_y[79:48], out_z[111:80]
  output logic [smtpb_pkg::TDATA_W-1:0]       m_axis_tdata,
  // tuser: clipped[0]
  output logic [0:0]                          m_axis_tuser,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [smtpb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [smtpb_pkg::WEIGHT_W-1:0]      cfg_wdata_i
);

  localparam int unsigned NUM_TARGETS = smtpb_pkg::NUM_TARGETS;
  localparam int unsigned TGT_W       = smtpb_pkg::TGT_W;
  localparam int unsigned LEN_W       = smtpb_pkg::LEN_W;
  localparam int unsigned VCNT_W      = smtpb_pkg::VCNT_W;
  localparam int unsigned POS_W       = smtpb_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_e;

  state_e                                state_q;
  logic [TGT_W-1:0]                      tgt_q;
  logic [LEN_W-1:0]                      len_q [NUM_TARGETS];
  logic [LEN_W-1:0]                      cur_q [NUM_TARGETS];
  logic signed [smtpb_pkg::WEIGHT_W-1:0] weight_q [NUM_TARGETS];
  logic [VCNT_W-1:0]                     vcnt_q;
  logic                                  p1_valid_q, p1_ok_q;
  logic [TGT_W-1:0]                      p1_tgt_q;
  logic                                  out_valid_q;
  logic [smtpb_pkg::TDATA_W-1:0]         out_data_q;
  logic                                  out_clip_q;

  // input unpacking
  smtpb_pkg::op_e                in_op;
  logic [1:0]                    in_tid;
  logic [TGT_W-1:0]              in_tidx;
  logic                          in_tid_ok;
  logic [smtpb_pkg::VERT_W-1:0]  in_vertex;
  logic signed [POS_W-1:0]       in_x, in_y, in_z;
  logic                          in_acc;

  // entry store ports
  logic                          st_we, st_re;
  logic [smtpb_pkg::ADDR_W-1:0]  st_waddr, st_raddr;
  smtpb_pkg::entry_t             st_wdata, st_rdata;

  logic                          issue_ok, last_tgt, hit, finish;
  logic [VCNT_W-1:0]             vcnt_next;
  smtpb_pkg::mac_ctrl_t          mac_ctrl;
  logic signed [POS_W-1:0]       res_x, res_y, res_z;
  logic                          res_clip, mac_busy;

  assign in_op     = smtpb_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_tid    = s_axis_tuser[3:2];
  assign in_tidx   = in_tid[TGT_W-1:0];
  assign in_tid_ok = 32'(in_tid) < NUM_TARGETS;
  assign in_vertex = s_axis_tdata[15:0];
  assign in_x      = s_axis_tdata[47:16];
  assign in_y      = s_axis_tdata[79:48];
  assign in_z      = s_axis_tdata[111:80];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Append writes the entry at the end of its target's list; drop it when full.
  assign st_we    = in_acc && (in_op == smtpb_pkg::OP_APPEND) && in_tid_ok &&
                    (len_q[in_tidx] < LEN_W'(smtpb_pkg::ENTRIES_PER_TARGET));
  assign st_waddr = smtpb_pkg::entry_addr(in_tidx, len_q[in_tidx]);
  assign st_wdata = '{z: in_z, y: in_y, x: in_x, vertex: in_vertex};

  // Read the entry under the cursor of one target per cycle.
  assign st_re    = (state_q == S_ISSUE);
  assign st_raddr = smtpb_pkg::entry_addr(tgt_q, cur_q[tgt_q]);
  assign issue_ok = (weight_q[tgt_q] != '0) && (cur_q[tgt_q] < len_q[tgt_q]);
  assign last_tgt = (tgt_q == TGT_W'(NUM_TARGETS - 1));

  // A read entry within its list and with a nonzero weight contributes when it names the current vertex.
  assign hit = p1_valid_q && p1_ok_q &&
               (st_rdata.vertex == smtpb_pkg::VERT_W'(vcnt_q));

  assign vcnt_next = (vcnt_q == VCNT_W'(smtpb_pkg::MAX_VERTICES - 1)) ? '0
                                                                      : vcnt_q + 1'b1;

  // Result is final once the pipe is empty; load it when the output slot frees.
  assign finish = (state_q == S_DRAIN) && !p1_valid_q && !mac_busy &&
                  (!out_valid_q || m_axis_tready);

  assign mac_ctrl.load       = in_acc && (in_op == smtpb_pkg::OP_BLEND);
  assign mac_ctrl.lane_valid = p1_valid_q;
  assign mac_ctrl.lane_hit   = hit;

  smtpb_ram #(
    .WIDTH (smtpb_pkg::ENTRY_W),
    .DEPTH (smtpb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  smtpb_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .base_x_i (in_x),
    .base_y_i (in_y),
    .base_z_i (in_z),
    .weight_i (weight_q[p1_tgt_q]),
    .entry_i  (st_rdata),
    .res_x_o  (res_x),
    .res_y_o  (res_y),
    .res_z_o  (res_z),
    .clip_o   (res_clip),
    .busy_o   (mac_busy)
  );

  // Sequencer, list bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= '0;
      vcnt_q      <= '0;
      p1_valid_q  <= 1'b0;
      p1_ok_q     <= 1'b0;
      p1_tgt_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TARGETS; i++) begin
        len_q[i]    <= '0;
        cur_q[i]    <= '0;
        weight_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i && (32'(cfg_index_i) < NUM_TARGETS)) begin
        weight_q[cfg_index_i[TGT_W-1:0]] <= cfg_wdata_i;
      end
      // hold a result until the receiver takes it
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      p1_valid_q <= (state_q == S_ISSUE);

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              smtpb_pkg::OP_CLEAR: begin
                for (int i = 0; i < NUM_TARGETS; i++) begin
                  len_q[i] <= '0;
                  cur_q[i] <= '0;
                end
                vcnt_q <= '0;
              end
              smtpb_pkg::OP_APPEND: begin
                if (st_we) begin
                  len_q[in_tidx] <= len_q[in_tidx] + 1'b1;
                end
              end
              smtpb_pkg::OP_RESTART: begin
                for (int i = 0; i < NUM_TARGETS; i++) begin
                  cur_q[i] <= '0;
                end
                vcnt_q <= '0;
              end
              smtpb_pkg::OP_BLEND: begin
                tgt_q   <= '0;
                state_q <= S_ISSUE;
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: begin
          p1_ok_q    <= issue_ok;
          p1_tgt_q   <= tgt_q;
          if (last_tgt) begin
            state_q <= S_DRAIN;
          end else begin
            tgt_q <= tgt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (finish) begin
            out_data_q  <= {res_z, res_y, res_x, smtpb_pkg::VERT_W'(vcnt_q)};
            out_clip_q  <= res_clip;
            vcnt_q      <= vcnt_next;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // advance the cursor of a target whose entry matched
      if (hit) begin
        cur_q[p1_tgt_q] <= cur_q[p1_tgt_q] + 1'b1;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_clip_q;

endmodule

>>> design/smtpb_checker.sv
// Port-level checker for the blender, bound to the top level.
`include "assert_macros.svh"

module smtpb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [smtpb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [smtpb_pkg::TDATA_W-1:0]     m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);

  logic in_acc, blend_acc, other_acc;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign blend_acc = in_acc && (s_axis_tuser[1:0] == smtpb_pkg::OP_BLEND);
  assign other_acc = in_acc && (s_axis_tuser[1:0] != smtpb_pkg::OP_BLEND);

  // A stalled result holds its value.
  `ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=>
              (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
  // A blend occupies the sequencer for the following cycle.
  `ASSERT_CLK(a_blend_busy, blend_acc |=> !s_axis_tready)
  // After a list command the input is ready again in the following cycle.
  `ASSERT_CLK(a_cmd_single, other_acc |=> s_axis_tready)
  // No result appears the cycle right after a blend is taken.
  `ASSERT_CLK(a_no_early_result, blend_acc |=> !$rose(m_axis_tvalid))

endmodule

bind sparse_morph_target_position_blend smtpb_checker u_smtpb_checker (.*);
